/* sv/fipid_pkg.sv */
// fipid_pkg: shared widths, constants, register codes and state type
// for the frequency incremental pid core
// no dependencies
package fipid_pkg;

    // field and state widths
    localparam int PERIOD_W  = 16;
    localparam int TGT_W     = 12;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 14;
    localparam int COEF_W    = 15;
    localparam int ACC_HI_W  = 20;
    localparam int STEP_W    = ACC_HI_W + COEF_W;
    localparam int SUM_W     = 32;
    localparam int FREQ_W    = 11;
    localparam int DRIVE_W   = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // frequency saturation limit
    localparam int FREQ_MAX = 2047;

    // drive = sum * 75 / 16, clamped; sums above this value clamp to full scale
    localparam int DRIVE_MUL     = 75;
    localparam int DRIVE_SHIFT   = 4;
    localparam int DRIVE_SUM_MAX = 13981;
    localparam int DRIVE_SUM_W   = 14;
    localparam int DRIVE_PROD_W  = 20;

    // request kind carried in tuser
    typedef enum logic {
        FUNC_CAPTURE = 1'b0,
        FUNC_TICK    = 1'b1
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_KP     = 2'd1,
        CFG_KI     = 2'd2,
        CFG_KD     = 2'd3
    } t_cfg_reg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MSTART,
        S_MUL,
        S_DRV
    } t_state;

endpackage

/* sv/frequency_incremental_pid_core.sv */
// Speed loop channel: a capture request (tuser 0) latches its period count
// when it exceeds MIN_PERIOD and gives no result. A tick request (tuser 1)
// measures frequency = TICK_RATE_HZ / period (0 with no latched period, at
// most 2047), runs one incremental pid step on the error to the target
// frequency, adds it to a saturating 32-bit sum and returns drive =
// clamp(sum * 75 / 16, 0, 65535) with the frequency. A tick runs the serial
// divider, then the serial pid multiply-accumulate, then the output
// sequencing; a tick with no latched period skips the divide. The result
// sits in an output register, so the next request is taken while it waits;
// a later tick holds in its last state until that result has been taken.
// depends on fipid_pkg, fipid_div, fipid_mac
module frequency_incremental_pid_core
    import fipid_pkg::*;
#(
    parameter int unsigned TICK_RATE_HZ = 1000000,
    parameter int unsigned MIN_PERIOD   = 600
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave request channel
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PERIOD_W-1:0]  i_s_tdata,   // [15:0] period_count
    input  logic                 i_s_tuser,   // [0] func
    // master result channel
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_W-1:0]     o_m_tdata,   // [15:0] drive_value, [26:16] measured_frequency
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam int SUM_X_W = SUM_W + 4;

    t_state                     r_state;
    t_state                     n_state;

    logic [TGT_W-1:0]           r_tgt;
    logic signed [GAIN_W-1:0]   r_kp;
    logic signed [GAIN_W-1:0]   r_ki;
    logic signed [GAIN_W-1:0]   r_kd;
    logic [PERIOD_W-1:0]        r_period;
    logic signed [ERR_W-1:0]    r_e1;
    logic signed [ERR_W-1:0]    r_e2;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [SUM_W-1:0]    r_sum;
    logic [FREQ_W-1:0]          r_freq;
    logic                       r_out_valid;
    logic [DRIVE_W-1:0]         r_out_drive;
    logic [FREQ_W-1:0]          r_out_freq;

    logic                       w_accept;
    logic                       w_div_start;
    logic                       w_mac_start;
    logic                       w_load_out;
    logic                       w_div_done;
    logic [FREQ_W-1:0]          w_div_freq;
    logic                       w_mac_done;
    logic signed [STEP_W-1:0]   w_step;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [SUM_X_W-1:0]  w_sum_x;
    logic signed [SUM_W-1:0]    w_sum_sat;
    logic [DRIVE_PROD_W-1:0]    w_prod;
    logic [DRIVE_W-1:0]         w_drive;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // period to frequency
    fipid_div #(
        .DIVIDEND (TICK_RATE_HZ)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (r_period),
        .o_done     (w_div_done),
        .o_quotient (w_div_freq)
    );

    // pid step
    fipid_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mac_start),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .i_err   (r_err),
        .i_err1  (r_e1),
        .i_err2  (r_e2),
        .o_done  (w_mac_done),
        .o_step  (w_step)
    );

    // error against the target
    assign w_err = signed'(ERR_W'(r_tgt)) - signed'(ERR_W'(w_div_freq));

    // saturating accumulate
    assign w_sum_x = SUM_X_W'(r_sum) + SUM_X_W'(w_step);
    always_comb begin
        if (w_sum_x > SUM_X_W'(SUM_MAX)) begin
            w_sum_sat = SUM_MAX;
        end else if (w_sum_x < SUM_X_W'(SUM_MIN)) begin
            w_sum_sat = SUM_MIN;
        end else begin
            w_sum_sat = w_sum_x[SUM_W-1:0];
        end
    end

    // drive scaling and clamp
    assign w_prod = DRIVE_PROD_W'(r_sum[DRIVE_SUM_W-1:0]) * DRIVE_PROD_W'(DRIVE_MUL);
    always_comb begin
        if (r_sum <= 0) begin
            w_drive = '0;
        end else if (r_sum > signed'(SUM_W'(DRIVE_SUM_MAX))) begin
            w_drive = '1;
        end else begin
            w_drive = w_prod[DRIVE_SHIFT +: DRIVE_W];
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_mac_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (t_func'(i_s_tuser) == FUNC_TICK)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                w_mac_start = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (w_mac_done) begin
                    n_state = S_DRV;
                end
            end
            S_DRV: begin
                if (!r_out_valid || i_m_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= '0;
            r_kp  <= '0;
            r_ki  <= '0;
            r_kd  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_TARGET: r_tgt <= i_cfg_data[TGT_W-1:0];
                CFG_KP:     r_kp  <= signed'(i_cfg_data);
                CFG_KI:     r_ki  <= signed'(i_cfg_data);
                CFG_KD:     r_kd  <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // loop state: latched period, error history, output sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_e1     <= '0;
            r_e2     <= '0;
            r_sum    <= '0;
        end else begin
            if (w_accept && (t_func'(i_s_tuser) == FUNC_CAPTURE)
                && (i_s_tdata > PERIOD_W'(MIN_PERIOD))) begin
                r_period <= i_s_tdata;
            end
            if ((r_state == S_MUL) && w_mac_done) begin
                r_sum <= w_sum_sat;
            end
            if (w_load_out) begin
                r_period <= '0;
                r_e2     <= r_e1;
                r_e1     <= r_err;
            end
        end
    end

    // per-tick working values
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && w_div_done) begin
            r_freq <= w_div_freq;
            r_err  <= w_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_drive <= w_drive;
            r_out_freq  <= r_freq;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - FREQ_W - DRIVE_W)'(0), r_out_freq, r_out_drive};

endmodule

/* sv/fipid_div.sv */
// fipid_div: bit-serial restoring divider, constant dividend over a period,
// one quotient bit per cycle, result saturated to the frequency range
// depends on fipid_pkg
module fipid_div
    import fipid_pkg::*;
#(
    parameter int unsigned DIVIDEND = 1000000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [FREQ_W-1:0]   o_quotient
);

    localparam int DIV_W = $clog2(DIVIDEND + 1);
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int QX_W  = (DIV_W > FREQ_W) ? DIV_W : FREQ_W;

    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic [DIV_W-1:0]    r_dvd;
    logic [DIV_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    logic [PERIOD_W:0]   w_trial;
    logic [PERIOD_W:0]   w_diff;
    logic                w_fit;
    logic [QX_W-1:0]     w_quo_x;

    // trial subtract of the next partial remainder
    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    // iteration counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_divisor == '0) begin
                    r_cnt  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= CNT_W'(DIV_W);
                end
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder, dividend and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_dvd <= DIV_W'(DIVIDEND);
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    // saturate to the frequency field
    assign w_quo_x    = QX_W'(r_quo);
    assign o_quotient = (w_quo_x > QX_W'(FREQ_MAX)) ? FREQ_W'(FREQ_MAX)
                                                    : w_quo_x[FREQ_W-1:0];
    assign o_done     = r_done;

endmodule

/* sv/fipid_mac.sv */
// fipid_mac: serial multiply-accumulate of the three pid terms, one bit of
// each error coefficient per cycle into a shared right-shifting accumulator
// depends on fipid_pkg
module fipid_mac
    import fipid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [GAIN_W-1:0] i_kp,
    input  logic signed [GAIN_W-1:0] i_ki,
    input  logic signed [GAIN_W-1:0] i_kd,
    input  logic signed [ERR_W-1:0]  i_err,
    input  logic signed [ERR_W-1:0]  i_err1,
    input  logic signed [ERR_W-1:0]  i_err2,
    output logic                     o_done,
    output logic signed [STEP_W-1:0] o_step
);

    localparam int CNT_W = $clog2(COEF_W + 1);

    logic [COEF_W-1:0]          r_cp;
    logic [COEF_W-1:0]          r_ci;
    logic [COEF_W-1:0]          r_cd;
    logic signed [ACC_HI_W-1:0] r_hi;
    logic [COEF_W-1:0]          r_lo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;

    logic signed [COEF_W-1:0]   w_d1;
    logic signed [COEF_W:0]     w_d2;
    logic signed [ACC_HI_W-1:0] w_pk;
    logic signed [ACC_HI_W-1:0] w_ik;
    logic signed [ACC_HI_W-1:0] w_dk;
    logic signed [ACC_HI_W-1:0] w_pp;
    logic signed [ACC_HI_W-1:0] w_sum;
    logic                       w_last;

    // first and second differences of the error
    assign w_d1 = COEF_W'(i_err) - COEF_W'(i_err1);
    assign w_d2 = (COEF_W + 1)'(i_err) - ((COEF_W + 1)'(i_err1) <<< 1)
                + (COEF_W + 1)'(i_err2);

    // partial product of this bit position, sign bit weighs negative
    assign w_pk   = r_cp[0] ? ACC_HI_W'(i_kp) : '0;
    assign w_ik   = r_ci[0] ? ACC_HI_W'(i_ki) : '0;
    assign w_dk   = r_cd[0] ? ACC_HI_W'(i_kd) : '0;
    assign w_pp   = w_pk + w_ik + w_dk;
    assign w_last = (r_cnt == CNT_W'(1));
    assign w_sum  = w_last ? (r_hi - w_pp) : (r_hi + w_pp);

    // bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(COEF_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (w_last) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // coefficient shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cp <= w_d1;
            r_ci <= COEF_W'(i_err);
            r_cd <= w_d2[COEF_W-1:0];
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_cnt != '0) begin
            r_cp <= {1'b0, r_cp[COEF_W-1:1]};
            r_ci <= {1'b0, r_ci[COEF_W-1:1]};
            r_cd <= {1'b0, r_cd[COEF_W-1:1]};
            r_hi <= w_sum >>> 1;
            r_lo <= {w_sum[0], r_lo[COEF_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_step = {r_hi, r_lo};

endmodule

/* test/frequency_incremental_pid_core_test.sv */
// self-checking testbench for frequency_incremental_pid_core: stream requests and
// register writes are driven here, and results are checked against a local pid predictor
// depends on fipid_pkg and frequency_incremental_pid_core
`timescale 1ns / 1ps

module frequency_incremental_pid_core_test;

    import fipid_pkg::*;

    localparam int unsigned TICK_RATE  = 1000000;
    localparam int unsigned MIN_PER    = 600;
    localparam longint      DRIVE_TOP  = 65535;
    localparam int          SETTLE_CYC = 64;
    localparam int          CYCLE_CAP  = 600000;
    localparam int          REPORT_MAX = 10;

    // tracks loop state and the drive/frequency results still owed by the core
    class speed_loop_checker;
        logic [TGT_W-1:0]           target;
        logic signed [GAIN_W-1:0]   kp, ki, kd;
        logic [PERIOD_W-1:0]        held;
        longint                     err1, err2;
        int                         acc_sum;
        logic [OUT_W-1:0]           pending_drive_q[$];
        int                         failures;

        function new();
            target   = '0;
            kp       = '0;
            ki       = '0;
            kd       = '0;
            held     = '0;
            err1     = 0;
            err2     = 0;
            acc_sum  = 0;
            failures = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TARGET: target = data[TGT_W-1:0];
                CFG_KP:     kp = data;
                CFG_KI:     ki = data;
                CFG_KD:     kd = data;
                default: ;
            endcase
        endfunction

        // one accepted request: captures update the latch, ticks owe a result
        function void note_request(t_func kind, logic [PERIOD_W-1:0] period);
            int unsigned freq;
            longint      e, step, total, drv;
            if (kind == FUNC_CAPTURE) begin
                if (period > MIN_PER)
                    held = period;
                return;
            end
            freq = (held == 0) ? 0 : TICK_RATE / held;
            if (freq > FREQ_MAX)
                freq = FREQ_MAX;
            e = longint'(target) - longint'(freq);
            step = longint'(kp) * (e - err1)
                 + longint'(ki) * e
                 + longint'(kd) * (e - 2 * err1 + err2);
            total = longint'(acc_sum) + step;
            if (total > 64'sd2147483647)
                total = 64'sd2147483647;
            if (total < -64'sd2147483648)
                total = -64'sd2147483648;
            acc_sum = int'(total);
            // division of a longint truncates toward zero
            drv = (longint'(acc_sum) * DRIVE_MUL) / 16;
            if (drv < 0)
                drv = 0;
            if (drv > DRIVE_TOP)
                drv = DRIVE_TOP;
            held = '0;
            err2 = err1;
            err1 = e;
            pending_drive_q.push_back({{(OUT_W-DRIVE_W-FREQ_W){1'b0}},
                                       freq[FREQ_W-1:0], drv[DRIVE_W-1:0]});
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= REPORT_MAX)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // compare one accepted result against the oldest owed one
        function void check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_drive_q.size() == 0) begin
                log_failure($sformatf("unexpected result: drive %0d freq %0d",
                                      got[DRIVE_W-1:0], got[DRIVE_W +: FREQ_W]));
                return;
            end
            want = pending_drive_q.pop_front();
            if (got !== want)
                log_failure($sformatf(
                    "drive exp %0d got %0d, freq exp %0d got %0d, pad exp 0 got %0h",
                    want[DRIVE_W-1:0], got[DRIVE_W-1:0],
                    want[DRIVE_W +: FREQ_W], got[DRIVE_W +: FREQ_W],
                    got[OUT_W-1:DRIVE_W+FREQ_W]));
        endfunction

        function int pending();
            return pending_drive_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [PERIOD_W-1:0]  i_s_tdata   = '0;  // [15:0] period_count
    logic                 i_s_tuser   = 1'b0; // [0] func
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [OUT_W-1:0]     o_m_tdata;          // [15:0] drive_value, [26:16] measured_frequency
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    speed_loop_checker sb;
    logic calm = 1'b0;
    int   cycles = 0;

    frequency_incremental_pid_core #(
        .TICK_RATE_HZ (TICK_RATE),
        .MIN_PERIOD   (MIN_PER)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("frequency_incremental_pid_core_test failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 37);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // one request on the slave channel, then a random pause unless calm is set
    task automatic send_request(input t_func kind, input logic [PERIOD_W-1:0] period);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= period;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        sb.note_request(kind, period);
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 37)
                gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every owed result is back and the core has gone quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input int target, input int kp, input int ki, input int kd);
        write_reg(CFG_TARGET, CFG_DAT_W'(target));
        write_reg(CFG_KP, CFG_DAT_W'(kp));
        write_reg(CFG_KI, CFG_DAT_W'(ki));
        write_reg(CFG_KD, CFG_DAT_W'(kd));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // steer the accumulated sum back into the unclamped drive range
    task automatic recenter_sum();
        longint gap_to_mid;
        longint gain;
        int     tries;
        tries = 0;
        gap_to_mid = 7000 - longint'(sb.acc_sum);
        while ((gap_to_mid < -3000 || gap_to_mid > 3000) && tries < 40) begin
            if (gap_to_mid >= 4095 || gap_to_mid <= -4095) begin
                gain = gap_to_mid / 4095;
                if (gain > 32767)
                    gain = 32767;
                if (gain < -32768)
                    gain = -32768;
                program_regs(4095, 0, int'(gain), 0);
            end else begin
                program_regs(int'(gap_to_mid < 0 ? -gap_to_mid : gap_to_mid), 0,
                             (gap_to_mid < 0) ? -1 : 1, 0);
            end
            send_request(FUNC_TICK, '0);
            settle();
            tries++;
            gap_to_mid = 7000 - longint'(sb.acc_sum);
        end
    endtask

    function automatic int pick_gain(input int spread);
        if ($urandom_range(0, 7) == 0)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // mostly capture-then-tick sequences, with stray and short requests mixed in
    task automatic run_phase(input int quota);
        int                  sent;
        logic [PERIOD_W-1:0] period;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 1) != 0)
                    period = PERIOD_W'($urandom_range(601, 2500));
                else
                    period = PERIOD_W'($urandom_range(601, 65535));
                send_request(FUNC_CAPTURE, period);
                sent++;
                if ($urandom_range(0, 4) == 0) begin
                    send_request(FUNC_CAPTURE, PERIOD_W'($urandom));
                    sent++;
                end
                send_request(FUNC_TICK, PERIOD_W'($urandom));
                sent++;
            end else begin
                if ($urandom_range(0, 1) != 0)
                    period = PERIOD_W'($urandom);
                else
                    period = PERIOD_W'($urandom_range(0, 600));
                send_request(t_func'($urandom_range(0, 1)), period);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero period, short captures, period extremes, latch clearing
        program_regs(1000, 2, 1, 1);
        send_request(FUNC_TICK, '0);
        send_request(FUNC_CAPTURE, '0);
        send_request(FUNC_CAPTURE, 16'd600);
        send_request(FUNC_TICK, 16'hFFFF);
        send_request(FUNC_CAPTURE, 16'd601);
        send_request(FUNC_TICK, '0);
        send_request(FUNC_CAPTURE, 16'hFFFF);
        send_request(FUNC_CAPTURE, 16'd600);
        send_request(FUNC_TICK, '0);
        send_request(FUNC_TICK, '0);
        send_request(FUNC_CAPTURE, 16'h5555);
        send_request(FUNC_CAPTURE, 16'hAAAA);
        send_request(FUNC_TICK, 16'h5555);
        send_request(FUNC_CAPTURE, 16'd1000);
        send_request(FUNC_TICK, 16'hAAAA);
        send_request(FUNC_CAPTURE, 16'd2000);
        send_request(FUNC_TICK, '0);
        send_request(FUNC_TICK, '0);
        settle();

        // extreme settings: sum saturation both ways and drive clamping
        program_regs(4095, 32767, 32767, 32767);
        run_phase(30);
        settle();
        program_regs(4095, -32768, -32768, -32768);
        run_phase(30);
        settle();
        program_regs(0, 32767, 32767, 32767);
        run_phase(30);
        settle();
        program_regs(0, -32768, -32768, -32768);
        run_phase(20);
        settle();

        // random settings, each starting from a mid-range sum
        for (int ph = 0; ph < 8; ph++) begin
            recenter_sum();
            program_regs(int'($urandom_range(0, 4095)), pick_gain(3), pick_gain(2),
                         pick_gain(2));
            calm <= (ph == 3);
            run_phase(48);
            settle();
        end
        calm <= 1'b0;

        // drain and finish
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.failures == 0)
            $display("frequency_incremental_pid_core_test passed");
        else
            $display("frequency_incremental_pid_core_test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/fipid_pkg.sv
sv/fipid_div.sv
sv/fipid_mac.sv
sv/frequency_incremental_pid_core.sv
test/frequency_incremental_pid_core_test.sv
